// ----- src/utt_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// Used by utt_front, utt_queue, utt_back and the top level; depends on nothing.
package utt_pkg;

	// Job queue depth; must be a power of two so the pointers wrap on their own.
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
	localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

	localparam logic [15:0] BomUnit       = 16'hFEFF;
	localparam logic [15:0] HiSurrBase    = 16'hD800;
	localparam logic [15:0] LoSurrBase    = 16'hDC00;
	localparam logic [20:0] SuppPlaneBase = 21'h010000;

	localparam logic [7:0] LeadMask2 = 8'hE0;
	localparam logic [7:0] LeadCode2 = 8'hC0;
	localparam logic [7:0] LeadMask3 = 8'hF0;
	localparam logic [7:0] LeadCode3 = 8'hE0;
	localparam logic [7:0] LeadMask4 = 8'hF8;
	localparam logic [7:0] LeadCode4 = 8'hF0;
	localparam logic [7:0] Lead2Bits = 8'h1F;
	localparam logic [7:0] Lead3Bits = 8'h0F;
	localparam logic [7:0] Lead4Bits = 8'h07;
	localparam logic [7:0] ContBits  = 8'h3F;

	// One job: up to three 16-bit units (mark plus at most a surrogate pair),
	// and the index of the last output byte of the job.
	typedef struct packed {
		logic [2:0]       last_idx;
		logic [2:0][15:0] units;
	} job_t;

	// Front to queue.
	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

	// Queue head as seen by the back end.
	typedef struct packed {
		logic valid;
		job_t job;
	} head_t;

endpackage

// ----- src/utt_front.sv -----
// Front end: accepts UTF-8 bytes, tracks the multi-byte decode state and
// turns each item into a job of UTF-16 units. Depends on utt_pkg.
module utt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     text_byte,
	input  logic           stream_start,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           q_full,
	output utt_pkg::push_t push
);
	import utt_pkg::*;

	logic [1:0]  pend_q;
	logic [20:0] cp_q;
	logic        mark_sent_q;

	logic        acc;
	logic [1:0]  pend_eff;
	logic [20:0] cp_eff;
	logic        mark;
	logic [1:0]  pend_nxt;
	logic [20:0] cp_nxt;
	logic [20:0] cp_cont;
	logic [20:0] cp_off;
	logic [1:0]  n_data;
	logic [2:0]  n_units;
	logic [15:0] d0;
	logic [15:0] d1;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	always_comb begin
		pend_eff = stream_start ? 2'd0 : pend_q;
		cp_eff   = stream_start ? 21'd0 : cp_q;
		mark     = stream_start || !mark_sent_q;
		cp_cont  = {cp_eff[14:0], text_byte[5:0] & ContBits[5:0]};
		cp_off   = cp_cont - SuppPlaneBase;
		pend_nxt = pend_eff;
		cp_nxt   = cp_eff;
		n_data   = 2'd0;
		d0       = 16'h0000;
		d1       = 16'h0000;
		if (pend_eff != 2'd0) begin
			pend_nxt = pend_eff - 2'd1;
			cp_nxt   = cp_cont;
			if (pend_nxt == 2'd0) begin
				cp_nxt = 21'd0;
				if (cp_cont >= SuppPlaneBase) begin
					n_data = 2'd2;
					d0     = HiSurrBase | {5'd0, cp_off[20:10]};
					d1     = LoSurrBase | {6'd0, cp_off[9:0]};
				end else begin
					n_data = 2'd1;
					d0     = cp_cont[15:0];
				end
			end
		end else if (!text_byte[7]) begin
			n_data = 2'd1;
			d0     = {8'h00, text_byte};
		end else if ((text_byte & LeadMask2) == LeadCode2) begin
			cp_nxt   = {13'd0, text_byte & Lead2Bits};
			pend_nxt = 2'd1;
		end else if ((text_byte & LeadMask3) == LeadCode3) begin
			cp_nxt   = {13'd0, text_byte & Lead3Bits};
			pend_nxt = 2'd2;
		end else if ((text_byte & LeadMask4) == LeadCode4) begin
			cp_nxt   = {13'd0, text_byte & Lead4Bits};
			pend_nxt = 2'd3;
		end else begin
			// Invalid lead byte: consumed, gives a zero unit.
			n_data = 2'd1;
		end
	end

	// Pack the mark ahead of the data units; empty jobs are not queued.
	// The last byte index is twice the unit count minus one.
	always_comb begin
		n_units            = {1'b0, n_data} + {2'd0, mark};
		push.valid         = acc && (mark || (n_data != 2'd0));
		push.job.last_idx  = {n_units[1:0] - 2'd1, 1'b1};
		if (mark) begin
			push.job.units = {d1, d0, BomUnit};
		end else begin
			push.job.units = {16'h0000, d1, d0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 2'd0;
			cp_q        <= 21'd0;
			mark_sent_q <= 1'b0;
		end else if (acc) begin
			pend_q      <= pend_nxt;
			cp_q        <= cp_nxt;
			mark_sent_q <= 1'b1;
		end
	end

endmodule

// ----- src/utt_queue.sv -----
// Small job queue between the decode front end and the byte serializer.
// Depends on utt_pkg.
module utt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  utt_pkg::push_t push,
	output logic           full,
	output utt_pkg::head_t head,
	input  logic           pop
);
	import utt_pkg::*;

	job_t                 mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueueCntW-1:0] cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full     = (cnt_q == QueueCntW'(QueueDepth));
	assign head.valid = (cnt_q != '0);
	assign head.job   = mem_q[rd_ptr_q];
	assign do_push  = push.valid && !full;
	assign do_pop   = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/utt_back.sv -----
// Back end: walks the queued job into the output register one byte per cycle while
// the output is not stalled, ordering each unit's bytes by the configured endianness. Depends on utt_pkg.
module utt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           msb_first,
	input  utt_pkg::head_t head,
	output logic           pop,
	output logic [7:0]     out_byte,
	output logic           run_last,
	output logic           out_valid,
	input  logic           out_ready
);
	import utt_pkg::*;

	logic [2:0]  idx_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        run_last_q;
	logic        advance;
	logic        at_last;
	logic [15:0] unit;
	logic [7:0]  next_byte;

	assign advance = head.valid && (!out_valid_q || out_ready);
	assign at_last = (idx_q == head.job.last_idx);
	assign pop     = advance && at_last;

	always_comb begin
		case (idx_q[2:1])
			2'd0:    unit = head.job.units[0];
			2'd1:    unit = head.job.units[1];
			default: unit = head.job.units[2];
		endcase
		// The high byte goes out on odd positions in little-endian order and
		// on even positions in big-endian order.
		next_byte = (idx_q[0] ^ msb_first) ? unit[15:8] : unit[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			idx_q       <= at_last ? 3'd0 : idx_q + 3'd1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= next_byte;
			run_last_q <= at_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

endmodule

// ----- src/utf8_to_utf16_transcoder.sv -----
// Top level of the UTF-8 to UTF-16 transcoder: byte order register, decode
// front end, job queue and byte serializer. Depends on utt_pkg and submodules.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid/in_ready    text_byte, stream_start
//   output    out        out_valid/out_ready  out_byte, run_last
//   config    in         cfg_we (no wait)     cfg_wdata (big_endian_out)
//
// The output port moves one byte per cycle while the output is not stalled. An
// item yields two output bytes for ASCII, up to six with a mark and a surrogate
// pair, and items that yield nothing (such as lead bytes) take none of the back end.
// The front end decodes in the cycle of acceptance and takes an item every
// cycle while the four-entry job queue has room; it does not wait for the
// output side. A held output byte stalls only the serializer until the queue
// fills. Reset is asynchronous and clears the decode state, queue pointers,
// output valid and the byte order register (little-endian).
module utf8_to_utf16_transcoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] text_byte,
	input  logic       stream_start,
	input  logic       in_valid,
	output logic       in_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       out_valid,
	input  logic       out_ready,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);
	import utt_pkg::*;

	logic  msb_first_q;
	push_t push;
	head_t head;
	logic  q_full;
	logic  pop;

	// The byte order register is read live by the serializer; the user must rewrite
	// it only while the block is idle, so no job sees a change midway (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msb_first_q <= 1'b0;
		end else if (cfg_we) begin
			msb_first_q <= cfg_wdata;
		end
	end

	utt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_byte    (text_byte),
		.stream_start (stream_start),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.q_full       (q_full),
		.push         (push)
	);

	utt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	utt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.msb_first  (msb_first_q),
		.head       (head),
		.pop        (pop),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

endmodule

// ----- src/utt_checker.sv -----
// Port-level checks for the UTF-8 to UTF-16 transcoder, bound to the top level.
// Depends only on the top level's ports.
module utt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic [7:0] text_byte,
	input logic       stream_start,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       out_valid,
	input logic       out_ready
);

	logic first_q;

	// Set until the first output byte after reset has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			first_q <= 1'b0;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(text_byte) && $stable(stream_start))
		else $error("input item changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("output item changed while stalled");

	a_run_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("gap inside the bytes of one input item");

	a_first_is_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_q |-> (out_byte == 8'hFE) || (out_byte == 8'hFF))
		else $error("first output after reset is not a byte order mark byte");

	a_idle_in_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid right after reset");

endmodule

bind utf8_to_utf16_transcoder utt_checker u_utt_checker (.*);
